@@ sv/qcrm_pkg.sv @@
package qcrm_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int STEPS        = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int ZW           = 36;
  localparam int XW           = 34;
  localparam int TRIGW        = 22;
  localparam int PIPE         = STEPS + 4;

  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [XW-1:0] INV_GAIN    = 34'sd652032874;

  localparam logic CMD_QUAT   = 1'b0;
  localparam logic CMD_CARDAN = 1'b1;

  typedef logic signed [17:0] ent_t;
  typedef logic signed [TRIGW-1:0] trig_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0: t = 36'sd843314856;   1: t = 36'sd497837829;
      2: t = 36'sd263043836;   3: t = 36'sd133525158;
      4: t = 36'sd67021686;    5: t = 36'sd33543515;
      6: t = 36'sd16775850;    7: t = 36'sd8388437;
      8: t = 36'sd4194282;     9: t = 36'sd2097149;
      10: t = 36'sd1048575;    11: t = 36'sd524287;
      12: t = 36'sd262143;     13: t = 36'sd131071;
      14: t = 36'sd65535;      15: t = 36'sd32767;
      16: t = 36'sd16383;      17: t = 36'sd8191;
      18: t = 36'sd4095;       19: t = 36'sd2047;
      20: t = 36'sd1023;       21: t = 36'sd511;
      22: t = 36'sd255;        default: t = 36'sd127;
    endcase
    return t;
  endfunction

  // Round half up at bit position s and saturate to the 18-bit output range.
  function automatic ent_t round_sat(input logic signed [127:0] v, input int s);
    logic signed [127:0] r;
    begin
      r = (v + (128'sd1 <<< (s - 1))) >>> s;
      if (r > 128'sd131071) return 18'sd131071;
      if (r < -128'sd131072) return -18'sd131072;
      return r[17:0];
    end
  endfunction

endpackage

@@ sv/qcrm_cordic.sv @@
module qcrm_cordic
  import qcrm_pkg::*;
(
  input  logic              clk,
  input  logic signed [19:0] angle,
  output trig_t             cos_o,
  output trig_t             sin_o
);

  logic signed [ZW-1:0] z_r [0:STEPS];
  logic signed [XW-1:0] x_r [0:STEPS];
  logic signed [XW-1:0] y_r [0:STEPS];
  logic                 neg_r [0:STEPS];
  logic signed [ZW-1:0] z0, z1;
  logic                 n0;
  logic signed [XW-1:0] xf, yf;

  // Range fold: once by two pi, then by pi with a sign flip.
  always_comb begin
    z0 = ZW'(angle) <<< 14;
    if (z0 > PI_Q30) z0 = z0 - TWO_PI_Q30;
    if (z0 < -PI_Q30) z0 = z0 + TWO_PI_Q30;
    n0 = 1'b0;
    z1 = z0;
    if (z0 > HALF_PI_Q30) begin
      z1 = z0 - PI_Q30;
      n0 = 1'b1;
    end else if (z0 < -HALF_PI_Q30) begin
      z1 = z0 + PI_Q30;
      n0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    z_r[0] <= z1;
    x_r[0] <= INV_GAIN;
    y_r[0] <= '0;
    neg_r[0] <= n0;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      neg_r[i+1] <= neg_r[i];
      if (z_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - atan_q30(i);
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + atan_q30(i);
      end
    end
  end

  always_comb begin
    xf = neg_r[STEPS] ? -x_r[STEPS] : x_r[STEPS];
    yf = neg_r[STEPS] ? -y_r[STEPS] : y_r[STEPS];
  end

  always_ff @(posedge clk) begin
    cos_o <= TRIGW'((xf + XW'(512)) >>> 10);
    sin_o <= TRIGW'((yf + XW'(512)) >>> 10);
  end

endmodule

@@ sv/qcrm_merge.sv @@
module qcrm_merge
  import qcrm_pkg::*;
(
  input  logic  clk,
  input  trig_t c0, s0, c1, s1, c2, s2,
  output ent_t  m [0:8]
);

  logic signed [43:0] c1c2_r, s2c0_r, s0s1_r, s0s2_r, c0s1_r, c1s2_r;
  logic signed [43:0] c0c2_r, s0c2_r, s0c1_r, c0c1_r;
  trig_t c2_r, s2_r, s1_r;

  always_ff @(posedge clk) begin
    c1c2_r <= c1 * c2; s2c0_r <= s2 * c0; s0s1_r <= s0 * s1;
    s0s2_r <= s0 * s2; c0s1_r <= c0 * s1; c1s2_r <= c1 * s2;
    c0c2_r <= c0 * c2; s0c2_r <= s0 * c2; s0c1_r <= s0 * c1;
    c0c1_r <= c0 * c1;
    c2_r <= c2; s2_r <= s2; s1_r <= s1;
  end

  // Products at 40 fraction bits; three-term ones at 60.
  always_ff @(posedge clk) begin
    m[0] <= round_sat(128'(c1c2_r) <<< 20, 44);
    m[1] <= round_sat((128'(s2c0_r) <<< 20) + 128'(s0s1_r) * 128'(c2_r), 44);
    m[2] <= round_sat((128'(s0s2_r) <<< 20) - 128'(c0s1_r) * 128'(c2_r), 44);
    m[3] <= round_sat(-(128'(c1s2_r) <<< 20), 44);
    m[4] <= round_sat((128'(c0c2_r) <<< 20) - 128'(s0s1_r) * 128'(s2_r), 44);
    m[5] <= round_sat((128'(s0c2_r) <<< 20) + 128'(c0s1_r) * 128'(s2_r), 44);
    m[6] <= round_sat(128'(s1_r) <<< 40, 44);
    m[7] <= round_sat(-(128'(s0c1_r) <<< 20), 44);
    m[8] <= round_sat(128'(c0c1_r) <<< 20, 44);
  end

endmodule

@@ sv/quat_or_cardan_to_rotation_matrix.sv @@
// Pipelined orientation to 3x3 rotation matrix. A transaction is taken on
// every cycle that start is high (busy is always low), and its matrix appears
// with out_valid at the end of the pipeline. STEPS, the number of CORDIC
// stages, is CORDIC_STEPS capped at 24. The pipeline is made of the fold
// register, the CORDIC stages, the rounding register and two product stages.
// The receiver cannot stall, so results must be captured on the out_valid cycle.
module quat_or_cardan_to_rotation_matrix
  import qcrm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_cmd,
  input  logic signed [19:0] in_component_0,
  input  logic signed [19:0] in_component_1,
  input  logic signed [19:0] in_component_2,
  input  logic signed [19:0] in_component_3,
  output logic               out_valid,
  output ent_t               out_r00, out_r01, out_r02,
  output ent_t               out_r10, out_r11, out_r12,
  output ent_t               out_r20, out_r21, out_r22
);

  trig_t c0, s0, c1, s1, c2, s2;
  ent_t  cm [0:8];
  ent_t  qm_r [0:8];
  ent_t  qd_r [2:PIPE-1][0:8];
  logic  v_r [0:PIPE-1];
  logic  cmd_r [0:PIPE-1];
  logic signed [39:0] aa, bb, cc, dd, ab, ac, ad, bc, bd, cd;

  assign busy = 1'b0;

  qcrm_cordic u_l0 (.clk(clk), .angle(in_component_0), .cos_o(c0), .sin_o(s0));
  qcrm_cordic u_l1 (.clk(clk), .angle(in_component_1), .cos_o(c1), .sin_o(s1));
  qcrm_cordic u_l2 (.clk(clk), .angle(in_component_2), .cos_o(c2), .sin_o(s2));
  qcrm_merge u_merge (.clk(clk), .c0(c0), .s0(s0), .c1(c1), .s1(s1),
                      .c2(c2), .s2(s2), .m(cm));

  always_comb begin
    aa = in_component_0 * in_component_0; bb = in_component_1 * in_component_1;
    cc = in_component_2 * in_component_2; dd = in_component_3 * in_component_3;
    ab = in_component_0 * in_component_1; ac = in_component_0 * in_component_2;
    ad = in_component_0 * in_component_3; bc = in_component_1 * in_component_2;
    bd = in_component_1 * in_component_3; cd = in_component_2 * in_component_3;
  end

  // Quaternion path: one product stage, then aligned to the Cardan latency.
  logic signed [39:0] p_r [0:9];
  always_ff @(posedge clk) begin
    p_r[0] <= aa; p_r[1] <= bb; p_r[2] <= cc; p_r[3] <= dd; p_r[4] <= ab;
    p_r[5] <= ac; p_r[6] <= ad; p_r[7] <= bc; p_r[8] <= bd; p_r[9] <= cd;
    qm_r[0] <= round_sat(128'(p_r[0]) + 128'(p_r[1]) - 128'(p_r[2]) - 128'(p_r[3]), 16);
    qm_r[1] <= round_sat(2 * (128'(p_r[7]) - 128'(p_r[6])), 16);
    qm_r[2] <= round_sat(2 * (128'(p_r[8]) + 128'(p_r[5])), 16);
    qm_r[3] <= round_sat(2 * (128'(p_r[7]) + 128'(p_r[6])), 16);
    qm_r[4] <= round_sat(128'(p_r[0]) - 128'(p_r[1]) + 128'(p_r[2]) - 128'(p_r[3]), 16);
    qm_r[5] <= round_sat(2 * (128'(p_r[9]) - 128'(p_r[4])), 16);
    qm_r[6] <= round_sat(2 * (128'(p_r[8]) - 128'(p_r[5])), 16);
    qm_r[7] <= round_sat(2 * (128'(p_r[9]) + 128'(p_r[4])), 16);
    qm_r[8] <= round_sat(128'(p_r[0]) - 128'(p_r[1]) - 128'(p_r[2]) + 128'(p_r[3]), 16);
    qd_r[2] <= qm_r;
  end

  for (genvar k = 2; k < PIPE - 1; k++) begin : g_qd
    always_ff @(posedge clk) qd_r[k+1] <= qd_r[k];
  end

  always_ff @(posedge clk) begin
    v_r[0] <= rst_n && start;
    cmd_r[0] <= in_cmd;
  end
  for (genvar k = 0; k < PIPE - 1; k++) begin : g_v
    always_ff @(posedge clk) begin
      v_r[k+1] <= rst_n && v_r[k];
      cmd_r[k+1] <= cmd_r[k];
    end
  end

  // v_r[PIPE-1] marks the output stage; qd_r[PIPE-1] and cm are aligned to it.
  ent_t sel [0:8];
  always_comb begin
    for (int k = 0; k < 9; k++)
      sel[k] = (cmd_r[PIPE-1] == CMD_CARDAN) ? cm[k] : qd_r[PIPE-1][k];
  end

  assign out_valid = v_r[PIPE-1];
  assign out_r00 = sel[0]; assign out_r01 = sel[1]; assign out_r02 = sel[2];
  assign out_r10 = sel[3]; assign out_r11 = sel[4]; assign out_r12 = sel[5];
  assign out_r20 = sel[6]; assign out_r21 = sel[7]; assign out_r22 = sel[8];

`ifndef SYNTHESIS
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, PIPE)) else $error("result without transaction");
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
`endif

endmodule

@@ test/tb_quat_or_cardan_to_rotation_matrix.sv @@
`timescale 1ns / 1ps

module tb_quat_or_cardan_to_rotation_matrix;
  import qcrm_pkg::*;

  localparam int NUM_RANDOM = 480;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = PIPE + 10;

  // 64-bit constants kept in plain integers for the prediction.
  localparam longint ANG_PI = 64'sd3373259426;
  localparam longint ANG_HALF_PI = 64'sd1686629713;
  localparam longint ANG_TWO_PI = 64'sd6746518852;
  localparam longint CORDIC_X0 = 64'sd652032874;
  localparam longint ENT_MAX = 64'sd131071;
  localparam longint ENT_MIN = -64'sd131072;
  localparam int ANGLE_TABLE_LEN = 24;

  typedef struct {
    ent_t e [9];
  } matrix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = CMD_QUAT;
  logic signed [19:0] in_component_0 = '0;
  logic signed [19:0] in_component_1 = '0;
  logic signed [19:0] in_component_2 = '0;
  logic signed [19:0] in_component_3 = '0;
  logic out_valid;
  ent_t out_r00, out_r01, out_r02, out_r10, out_r11, out_r12, out_r20, out_r21, out_r22;

  matrix_t expected_matrices [$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit sender_pause = 1'b0;

  longint angle_atan [ANGLE_TABLE_LEN] = '{
    843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149,
    1048575, 524287, 262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047, 1023, 511, 255, 127
  };

  quat_or_cardan_to_rotation_matrix u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd),
    .in_component_0(in_component_0), .in_component_1(in_component_1),
    .in_component_2(in_component_2), .in_component_3(in_component_3),
    .out_valid(out_valid),
    .out_r00(out_r00), .out_r01(out_r01), .out_r02(out_r02),
    .out_r10(out_r10), .out_r11(out_r11), .out_r12(out_r12),
    .out_r20(out_r20), .out_r21(out_r21), .out_r22(out_r22)
  );

  always #2 clk = ~clk;

  function automatic longint shift_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint shift_round(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic ent_t clamp_entry(longint v);
    if (v > ENT_MAX) return ent_t'(ENT_MAX);
    if (v < ENT_MIN) return ent_t'(ENT_MIN);
    return ent_t'(v);
  endfunction

  // Cosine and sine at 20 fraction bits of an angle given at 16 fraction bits.
  task automatic angle_sincos(input longint a16, output longint c20, output longint s20);
    longint z, x, y, nx;
    bit flip;
    int n;
    z = a16 * 16384;
    x = CORDIC_X0;
    y = 0;
    flip = 1'b0;
    n = (CORDIC_STEPS > ANGLE_TABLE_LEN) ? ANGLE_TABLE_LEN : CORDIC_STEPS;
    if (z > ANG_PI) z -= ANG_TWO_PI;
    if (z < -ANG_PI) z += ANG_TWO_PI;
    if (z > ANG_HALF_PI) begin
      z -= ANG_PI;
      flip = 1'b1;
    end else if (z < -ANG_HALF_PI) begin
      z += ANG_PI;
      flip = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = x - shift_floor(y, i);
        y = y + shift_floor(x, i);
        z -= angle_atan[i];
      end else begin
        nx = x + shift_floor(y, i);
        y = y - shift_floor(x, i);
        z += angle_atan[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c20 = shift_round(x, 10);
    s20 = shift_round(y, 10);
  endtask

  task automatic predict_rotation(input logic cmd, input logic signed [19:0] p0,
                                  input logic signed [19:0] p1, input logic signed [19:0] p2,
                                  input logic signed [19:0] p3, output matrix_t m);
    longint a, b, c, d, w;
    longint c0, s0, c1, s1, c2, s2;
    longint t [9];
    a = p0; b = p1; c = p2; d = p3;
    w = 64'sd1 <<< 20;
    if (cmd == CMD_QUAT) begin
      t[0] = a*a + b*b - c*c - d*d;
      t[1] = 2 * (b*c - a*d);
      t[2] = 2 * (b*d + a*c);
      t[3] = 2 * (c*b + a*d);
      t[4] = a*a - b*b + c*c - d*d;
      t[5] = 2 * (c*d - a*b);
      t[6] = 2 * (d*b - a*c);
      t[7] = 2 * (d*c + a*b);
      t[8] = a*a - b*b - c*c + d*d;
      for (int k = 0; k < 9; k++) m.e[k] = clamp_entry(shift_round(t[k], 16));
    end else begin
      angle_sincos(a, c0, s0);
      angle_sincos(b, c1, s1);
      angle_sincos(c, c2, s2);
      t[0] = c1 * c2 * w;
      t[1] = s2 * c0 * w + s0 * s1 * c2;
      t[2] = s0 * s2 * w - c0 * s1 * c2;
      t[3] = -(c1 * s2 * w);
      t[4] = c0 * c2 * w - s0 * s1 * s2;
      t[5] = s0 * c2 * w + c0 * s1 * s2;
      t[6] = s1 * w * w;
      t[7] = -(s0 * c1 * w);
      t[8] = c0 * c1 * w;
      for (int k = 0; k < 9; k++) m.e[k] = clamp_entry(shift_round(t[k], 44));
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("ERROR %0t: %s", $realtime, what);
  endtask

  // Drives one orientation and waits until the block takes it.
  task automatic send_orientation(input logic cmd, input logic signed [19:0] p0,
                                  input logic signed [19:0] p1, input logic signed [19:0] p2,
                                  input logic signed [19:0] p3);
    matrix_t m;
    predict_rotation(cmd, p0, p1, p2, p3, m);
    start <= 1'b1;
    in_cmd <= cmd;
    in_component_0 <= p0;
    in_component_1 <= p1;
    in_component_2 <= p2;
    in_component_3 <= p3;
    do @(posedge clk); while (busy);
    expected_matrices.push_back(m);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Start is only lowered here when it is still high, so that a following
  // send in the same time step is the only driver of start.
  task automatic wait_drained();
    if (start) start <= 1'b0;
    while (expected_matrices.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [19:0] random_component();
    case ($urandom_range(0, 5))
      0: return 20'sh7FFFF;
      1: return 20'sh80000;
      2: return 20'($urandom_range(0, 131072) - 65536);
      default: return 20'($urandom);
    endcase
  endfunction

  task automatic test_quaternion_directed();
    send_orientation(CMD_QUAT, 20'sd65536, 0, 0, 0);
    send_orientation(CMD_QUAT, 0, 20'sd65536, 0, 0);
    send_orientation(CMD_QUAT, 0, 0, 20'sd65536, 0);
    send_orientation(CMD_QUAT, 0, 0, 0, 20'sd65536);
    send_orientation(CMD_QUAT, 20'sd32768, 20'sd32768, 20'sd32768, 20'sd32768);
    send_orientation(CMD_QUAT, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF);
    send_orientation(CMD_QUAT, 20'sh80000, 20'sh80000, 20'sh80000, 20'sh80000);
    send_orientation(CMD_QUAT, 20'sh80000, 20'sh7FFFF, 20'sh80000, 20'sh7FFFF);
    send_orientation(CMD_QUAT, 20'sd1, -20'sd1, 20'sd1, 0);
    send_orientation(CMD_QUAT, 0, 0, 0, 0);
  endtask

  task automatic test_cardan_directed();
    send_orientation(CMD_CARDAN, 0, 0, 0, 20'sh7FFFF);
    // Angles near plus and minus pi and pi/2 exercise both folds.
    send_orientation(CMD_CARDAN, 20'sd205887, -20'sd205887, 20'sd102944, 0);
    send_orientation(CMD_CARDAN, 20'sd205888, -20'sd205888, -20'sd102944, 0);
    send_orientation(CMD_CARDAN, 20'sd102943, 20'sd102944, 20'sd102945, 0);
    send_orientation(CMD_CARDAN, 20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 20'sh80000);
    send_orientation(CMD_CARDAN, 20'sh80000, 20'sh7FFFF, 20'sh80000, 20'sh80000);
    send_orientation(CMD_CARDAN, 20'sd411775, -20'sd411775, 20'sd1, 0);
    send_orientation(CMD_CARDAN, -20'sd1, 20'sd34315, -20'sd68629, 20'sh55555);
    send_orientation(CMD_CARDAN, 20'sd65536, 20'sd65536, 20'sd65536, 0);
  endtask

  task automatic test_random_stream();
    int left;
    left = NUM_RANDOM;
    while (left > 0) begin
      automatic int burst = $urandom_range(1, 30);
      for (int i = 0; i < burst && left > 0; i++, left--)
        send_orientation(logic'($urandom_range(0, 1)), random_component(),
                         random_component(), random_component(), random_component());
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, PIPE + 4));
      if (left == NUM_RANDOM / 2) wait_drained();
    end
    if (start) start <= 1'b0;
  endtask

  // Result capture and comparison.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      ent_t got [9];
      got = '{out_r00, out_r01, out_r02, out_r10, out_r11, out_r12,
              out_r20, out_r21, out_r22};
      if (expected_matrices.size() == 0) begin
        report_mismatch("matrix with no orientation pending");
      end else begin
        matrix_t want;
        want = expected_matrices.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[k] !== want.e[k])
            report_mismatch($sformatf("r%0d%0d got %0d want %0d",
                                      k / 3, k % 3, got[k], want.e[k]));
      end
    end
  end

  // Watchdog on cycles with no transaction in either direction.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("tb_quat_or_cardan_to_rotation_matrix: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_quaternion_directed();
    test_cardan_directed();
    wait_drained();
    test_random_stream();
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_matrices.size() == 0)
      $display("tb_quat_or_cardan_to_rotation_matrix: PASS");
    else
      $display("tb_quat_or_cardan_to_rotation_matrix: FAIL");
    $finish;
  end

endmodule

@@ quat_or_cardan_to_rotation_matrix.f @@
sv/qcrm_pkg.sv
sv/qcrm_cordic.sv
sv/qcrm_merge.sv
sv/quat_or_cardan_to_rotation_matrix.sv
test/tb_quat_or_cardan_to_rotation_matrix.sv
